// ===== src/quaternion_scale_translate_to_matrix_top_macros.svh =====
// Assertion macros used by the top-level RTL of the quaternion transform block.
`ifndef QUATERNION_SCALE_TRANSLATE_TO_MATRIX_TOP_MACROS_SVH
`define QUATERNION_SCALE_TRANSLATE_TO_MATRIX_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check a property while out of reset.
`define QSTM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define QSTM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define QSTM_ASSERT(label, prop, msg)
`define QSTM_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== src/qstm_pkg.sv =====
`default_nettype none

package qstm_pkg;

    localparam int QUAT_W          = 16;
    localparam int SCALE_W         = 16;
    localparam int TRANS_W         = 32;
    localparam int OUT_W           = 32;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int SQ_W            = 2 * QUAT_W;
    localparam int NUM_ROT         = 9;
    localparam int NUM_AXES        = 3;
    localparam int NUM_COLS        = 4;
    localparam int IN_DATA_W       = 208;
    localparam int OUT_DATA_W      = 384;

    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int OUT_FRAC_BITS_DEF  = 16;

    typedef struct packed {
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [SCALE_W-1:0] z;
        logic signed [SCALE_W-1:0] y;
        logic signed [SCALE_W-1:0] x;
    } scale_t;

    typedef struct packed {
        logic signed [TRANS_W-1:0] z;
        logic signed [TRANS_W-1:0] y;
        logic signed [TRANS_W-1:0] x;
    } trans_t;

    typedef struct packed {
        logic signed [SQ_W-1:0] xx;
        logic signed [SQ_W-1:0] yy;
        logic signed [SQ_W-1:0] zz;
        logic signed [SQ_W-1:0] xy;
        logic signed [SQ_W-1:0] yz;
        logic signed [SQ_W-1:0] xz;
        logic signed [SQ_W-1:0] xw;
        logic signed [SQ_W-1:0] yw;
        logic signed [SQ_W-1:0] zw;
    } sq_t;

endpackage

`default_nettype wire

// ===== src/quaternion_scale_translate_to_matrix_top.sv =====
// Quaternion, scale and translation to the top three rows of a 4x4 affine transform.
//
// Input stream: one transaction per object carries quaternion w,x,y,z (Q2.14 by default),
// scale x,y,z (Q8.8) and translation x,y,z (Q16.16). Output stream: one transaction per
// input with the 3x4 matrix in Q16.16, rows in order, four columns per row; the fourth
// column is the translation unchanged, the rotation-scale entries round to nearest (ties
// away from zero) and saturate to 32 bits.
//
// The path from input acceptance to output valid has one register stage each for products,
// rotation sums, scale multiply, and round and saturate. Throughput is one transaction per
// cycle while the receiver takes results.
//
// Reset clears all stage valid flags; no output is presented until new input arrives.
// When the receiver holds m_tready low, the last stage holds its result and the stages
// behind it fill; s_tready drops only when every stage holds a transaction.
`default_nettype none

`include "quaternion_scale_translate_to_matrix_top_macros.svh"

module quaternion_scale_translate_to_matrix_top
    import qstm_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS  = OUT_FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z, trans_x, trans_y, trans_z
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_r0_c0, m_r0_c1, m_r0_c2, m_r0_c3, m_r1_c0 .. m_r1_c3, m_r2_c0 .. m_r2_c3
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int ROT_W = (2 * QUAT_FRAC_BITS + 3 > 35) ? 2 * QUAT_FRAC_BITS + 3 : 35;
    localparam int MUL_W = ROT_W + SCALE_W;

    quat_t  in_quat;
    scale_t in_scale;
    trans_t in_trans;

    logic   v1, r1;
    sq_t    sq1;
    scale_t scale1;
    trans_t trans1;

    logic                    v2, r2;
    logic signed [ROT_W-1:0] rot2 [NUM_ROT];
    scale_t                  scale2;
    trans_t                  trans2;

    logic                    v3, r3;
    logic signed [MUL_W-1:0] prod3 [NUM_ROT];
    trans_t                  trans3;

    logic signed [OUT_W-1:0] ent4 [NUM_ROT];
    trans_t                  trans4;
    logic signed [TRANS_W-1:0] trans_col [NUM_AXES];

    assign in_quat.w  = s_tdata[15:0];
    assign in_quat.x  = s_tdata[31:16];
    assign in_quat.y  = s_tdata[47:32];
    assign in_quat.z  = s_tdata[63:48];
    assign in_scale.x = s_tdata[79:64];
    assign in_scale.y = s_tdata[95:80];
    assign in_scale.z = s_tdata[111:96];
    assign in_trans.x = s_tdata[143:112];
    assign in_trans.y = s_tdata[175:144];
    assign in_trans.z = s_tdata[207:176];

    qstm_prod u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_quat   (in_quat),
        .in_scale  (in_scale),
        .in_trans  (in_trans),
        .out_valid (v1),
        .out_ready (r1),
        .out_sq    (sq1),
        .out_scale (scale1),
        .out_trans (trans1)
    );

    qstm_rot #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .ROT_W          (ROT_W)
    ) u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_sq     (sq1),
        .in_scale  (scale1),
        .in_trans  (trans1),
        .out_valid (v2),
        .out_ready (r2),
        .out_rot   (rot2),
        .out_scale (scale2),
        .out_trans (trans2)
    );

    qstm_mul #(
        .ROT_W (ROT_W)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_rot    (rot2),
        .in_scale  (scale2),
        .in_trans  (trans2),
        .out_valid (v3),
        .out_ready (r3),
        .out_prod  (prod3),
        .out_trans (trans3)
    );

    qstm_rnd #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS),
        .MUL_W          (MUL_W)
    ) u_rnd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r3),
        .in_prod   (prod3),
        .in_trans  (trans3),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ent   (ent4),
        .out_trans (trans4)
    );

    assign trans_col[0] = trans4.x;
    assign trans_col[1] = trans4.y;
    assign trans_col[2] = trans4.z;

    always_comb begin
        for (int row = 0; row < NUM_AXES; row++) begin
            for (int col = 0; col < NUM_AXES; col++) begin
                m_tdata[(row*NUM_COLS + col)*OUT_W +: OUT_W] = ent4[row*NUM_AXES + col];
            end
            m_tdata[(row*NUM_COLS + NUM_AXES)*OUT_W +: OUT_W] = trans_col[row];
        end
    end

    `QSTM_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "output valid after reset")
    `QSTM_ASSERT(a_no_stall_ready, (m_tready || !m_tvalid) |-> s_tready, "input stalled with free pipeline")
    `QSTM_ASSERT(a_out_from_stage, $rose(m_tvalid) |-> $past(v3), "output valid without a transaction behind it")

endmodule

`default_nettype wire

// ===== src/qstm_prod.sv =====
`default_nettype none

module qstm_prod
    import qstm_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire quat_t  in_quat,
    input  wire scale_t in_scale,
    input  wire trans_t in_trans,
    output logic        out_valid,
    input  wire logic   out_ready,
    output sq_t         out_sq,
    output scale_t      out_scale,
    output trans_t      out_trans
);

    logic   valid_reg;
    sq_t    sq_reg, sq_next;
    scale_t scale_reg;
    trans_t trans_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        sq_next.xx = in_quat.x * in_quat.x;
        sq_next.yy = in_quat.y * in_quat.y;
        sq_next.zz = in_quat.z * in_quat.z;
        sq_next.xy = in_quat.x * in_quat.y;
        sq_next.yz = in_quat.y * in_quat.z;
        sq_next.xz = in_quat.x * in_quat.z;
        sq_next.xw = in_quat.x * in_quat.w;
        sq_next.yw = in_quat.y * in_quat.w;
        sq_next.zw = in_quat.z * in_quat.w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sq_reg    <= sq_next;
            scale_reg <= in_scale;
            trans_reg <= in_trans;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_scale = scale_reg;
    assign out_trans = trans_reg;

endmodule

`default_nettype wire

// ===== src/qstm_rot.sv =====
`default_nettype none

module qstm_rot
    import qstm_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int ROT_W          = 35
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire sq_t          in_sq,
    input  wire scale_t       in_scale,
    input  wire trans_t       in_trans,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic signed [ROT_W-1:0] out_rot [NUM_ROT],
    output scale_t            out_scale,
    output trans_t            out_trans
);

    localparam logic signed [ROT_W-1:0] ONE = ROT_W'(1) << (2 * QUAT_FRAC_BITS);

    logic                    valid_reg;
    logic signed [ROT_W-1:0] rot_reg  [NUM_ROT];
    logic signed [ROT_W-1:0] rot_next [NUM_ROT];
    scale_t                  scale_reg;
    trans_t                  trans_reg;

    function automatic logic signed [ROT_W-1:0] sext(input logic signed [SQ_W-1:0] v);
        return $signed({{(ROT_W-SQ_W){v[SQ_W-1]}}, v});
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        rot_next[0] = ONE - ((sext(in_sq.yy) + sext(in_sq.zz)) <<< 1);
        rot_next[1] = (sext(in_sq.xy) - sext(in_sq.zw)) <<< 1;
        rot_next[2] = (sext(in_sq.xz) + sext(in_sq.yw)) <<< 1;
        rot_next[3] = (sext(in_sq.xy) + sext(in_sq.zw)) <<< 1;
        rot_next[4] = ONE - ((sext(in_sq.xx) + sext(in_sq.zz)) <<< 1);
        rot_next[5] = (sext(in_sq.yz) - sext(in_sq.xw)) <<< 1;
        rot_next[6] = (sext(in_sq.xz) - sext(in_sq.yw)) <<< 1;
        rot_next[7] = (sext(in_sq.yz) + sext(in_sq.xw)) <<< 1;
        rot_next[8] = ONE - ((sext(in_sq.xx) + sext(in_sq.yy)) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rot_reg   <= rot_next;
            scale_reg <= in_scale;
            trans_reg <= in_trans;
        end
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;
    assign out_scale = scale_reg;
    assign out_trans = trans_reg;

endmodule

`default_nettype wire

// ===== src/qstm_mul.sv =====
`default_nettype none

module qstm_mul
    import qstm_pkg::*;
#(
    parameter int ROT_W = 35
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic signed [ROT_W-1:0] in_rot [NUM_ROT],
    input  wire scale_t       in_scale,
    input  wire trans_t       in_trans,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic signed [ROT_W+SCALE_W-1:0] out_prod [NUM_ROT],
    output trans_t            out_trans
);

    localparam int MUL_W = ROT_W + SCALE_W;

    logic                    valid_reg;
    logic signed [MUL_W-1:0] prod_reg  [NUM_ROT];
    logic signed [MUL_W-1:0] prod_next [NUM_ROT];
    logic signed [SCALE_W-1:0] col_scale [NUM_AXES];
    trans_t                  trans_reg;

    assign in_ready     = !valid_reg || out_ready;
    assign col_scale[0] = in_scale.x;
    assign col_scale[1] = in_scale.y;
    assign col_scale[2] = in_scale.z;

    always_comb begin
        for (int i = 0; i < NUM_ROT; i++) begin
            prod_next[i] = $signed({{SCALE_W{in_rot[i][ROT_W-1]}}, in_rot[i]})
                         * $signed({{ROT_W{col_scale[i % NUM_AXES][SCALE_W-1]}},
                                    col_scale[i % NUM_AXES]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prod_reg  <= prod_next;
            trans_reg <= in_trans;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_trans = trans_reg;

endmodule

`default_nettype wire

// ===== src/qstm_rnd.sv =====
`default_nettype none

module qstm_rnd
    import qstm_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS  = OUT_FRAC_BITS_DEF,
    parameter int MUL_W          = 51
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic signed [MUL_W-1:0] in_prod [NUM_ROT],
    input  wire trans_t       in_trans,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic signed [OUT_W-1:0] out_ent [NUM_ROT],
    output trans_t            out_trans
);

    localparam int SHIFT = 2 * QUAT_FRAC_BITS + SCALE_FRAC_BITS - OUT_FRAC_BITS;
    localparam int LSH   = (SHIFT < 0) ? -SHIFT : 0;
    localparam int EXT_W = MUL_W + 1 + LSH;

    logic                    valid_reg;
    logic signed [OUT_W-1:0] ent_reg  [NUM_ROT];
    logic signed [OUT_W-1:0] ent_next [NUM_ROT];
    trans_t                  trans_reg;

    assign in_ready = !valid_reg || out_ready;

    for (genvar i = 0; i < NUM_ROT; i++) begin : g_lane
        logic signed [EXT_W-1:0] ext;
        logic signed [EXT_W-1:0] aligned;

        assign ext = $signed({{(EXT_W-MUL_W){in_prod[i][MUL_W-1]}}, in_prod[i]});

        if (SHIFT > 0) begin : g_rnd
            localparam logic signed [EXT_W-1:0] HALF = EXT_W'(1) << (SHIFT - 1);
            assign aligned = (ext + HALF - $signed({{(EXT_W-1){1'b0}}, ext[EXT_W-1]}))
                             >>> SHIFT;
        end else if (SHIFT < 0) begin : g_lsh
            assign aligned = ext <<< LSH;
        end else begin : g_pass
            assign aligned = ext;
        end

        always_comb begin
            if (aligned[EXT_W-1:OUT_W-1] == {(EXT_W-OUT_W+1){1'b0}}
                || aligned[EXT_W-1:OUT_W-1] == {(EXT_W-OUT_W+1){1'b1}}) begin
                ent_next[i] = aligned[OUT_W-1:0];
            end else if (aligned[EXT_W-1]) begin
                ent_next[i] = $signed({1'b1, {(OUT_W-1){1'b0}}});
            end else begin
                ent_next[i] = $signed({1'b0, {(OUT_W-1){1'b1}}});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ent_reg   <= ent_next;
            trans_reg <= in_trans;
        end
    end

    assign out_valid = valid_reg;
    assign out_ent   = ent_reg;
    assign out_trans = trans_reg;

endmodule

`default_nettype wire

// ===== dv/tb_quaternion_scale_translate_to_matrix_top.sv =====
`timescale 1ns / 1ps

module tb_quaternion_scale_translate_to_matrix_top
    import qstm_pkg::*;
();

    localparam int ROUND_SHIFT = 2 * QUAT_FRAC_BITS_DEF + SCALE_FRAC_BITS - OUT_FRAC_BITS_DEF;
    localparam int NUM_ROWS    = 3;
    localparam int NUM_ENTRIES = NUM_ROWS * NUM_COLS;
    localparam int CYCLE_LIMIT = 200000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [OUT_DATA_W-1:0] pending_matrices[$];
    bit                    idle_on        = 1'b1;
    int unsigned           mismatch_count = 0;
    int unsigned           matrix_count   = 0;
    int unsigned           saturated_count = 0;
    int unsigned           cycle_count    = 0;
    int unsigned           ready_hold     = 0;

    quaternion_scale_translate_to_matrix_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [OUT_W-1:0] round_sat_entry(longint rot, longint scl);
        bit                neg;
        longint unsigned   mag;
        longint unsigned   smag;
        longint unsigned   prod;
        longint unsigned   lim;
        neg  = (rot < 0) != (scl < 0);
        mag  = (rot < 0) ? -rot : rot;
        smag = (scl < 0) ? -scl : scl;
        prod = mag * smag;
        prod = (prod + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (prod > lim) begin
            prod = lim;
        end
        if (neg) begin
            prod = -prod;
        end
        return prod[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_DATA_W-1:0] transform_matrix(logic [IN_DATA_W-1:0] d);
        longint                w, x, y, z, sx, sy, sz, one;
        longint                xx, yy, zz, xy, yz, xz, xw, yw, zw;
        logic [OUT_DATA_W-1:0] m;
        w   = $signed(d[15:0]);
        x   = $signed(d[31:16]);
        y   = $signed(d[47:32]);
        z   = $signed(d[63:48]);
        sx  = $signed(d[79:64]);
        sy  = $signed(d[95:80]);
        sz  = $signed(d[111:96]);
        one = longint'(1) << (2 * QUAT_FRAC_BITS_DEF);
        xx  = x * x;
        yy  = y * y;
        zz  = z * z;
        xy  = x * y;
        yz  = y * z;
        xz  = x * z;
        xw  = x * w;
        yw  = y * w;
        zw  = z * w;
        m[0*OUT_W +: OUT_W]  = round_sat_entry(one - 2 * (yy + zz), sx);
        m[1*OUT_W +: OUT_W]  = round_sat_entry(2 * (xy - zw), sy);
        m[2*OUT_W +: OUT_W]  = round_sat_entry(2 * (xz + yw), sz);
        m[3*OUT_W +: OUT_W]  = d[143:112];
        m[4*OUT_W +: OUT_W]  = round_sat_entry(2 * (xy + zw), sx);
        m[5*OUT_W +: OUT_W]  = round_sat_entry(one - 2 * (xx + zz), sy);
        m[6*OUT_W +: OUT_W]  = round_sat_entry(2 * (yz - xw), sz);
        m[7*OUT_W +: OUT_W]  = d[175:144];
        m[8*OUT_W +: OUT_W]  = round_sat_entry(2 * (xz - yw), sx);
        m[9*OUT_W +: OUT_W]  = round_sat_entry(2 * (yz + xw), sy);
        m[10*OUT_W +: OUT_W] = round_sat_entry(one - 2 * (xx + yy), sz);
        m[11*OUT_W +: OUT_W] = d[207:176];
        return m;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_transform(
        logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
        logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
        logic [31:0] tx, logic [31:0] ty, logic [31:0] tz
    );
        return {tz, ty, tx, sz, sy, sx, z, y, x, w};
    endfunction

    function automatic logic [15:0] near_unit_component();
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [15:0] moderate_scale();
        return 16'(int'($urandom_range(0, 4096)) - 2048);
    endfunction

    task automatic send_transform(logic [IN_DATA_W-1:0] d);
        int unsigned           gap;
        logic [OUT_DATA_W-1:0] expected;
        gap      = idle_on ? $urandom_range(0, 3) : 0;
        expected = transform_matrix(d);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_matrices.push_back(expected);
    endtask

    task automatic test_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        send_transform(pack_transform(16'sd16384, 0, 0, 0, 16'sd256, 16'sd256, 16'sd256,
                                      0, 0, 0));
        send_transform(pack_transform(16'sd16384, 0, 0, 0, 16'sd256, 16'sd256, 16'sd256,
                                      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_transform(pack_transform(0, 0, 0, 0, 16'sd256, 16'sd256, 16'sd256,
                                      32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001));
        send_transform(pack_transform(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                      16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0));
        send_transform(pack_transform(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                      16'h8000, 16'h8000, 16'h8000, 0, 0, 0));
        send_transform(pack_transform(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                      0, 0, 0, 32'h1234_5678, 0, 0));
        send_transform(pack_transform(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                      16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0));
        send_transform(pack_transform(0, 16'sd16384, 0, 0, 16'sd256, -16'sd256, 16'sd512,
                                      0, 0, 0));
        send_transform(pack_transform(0, 16'sd512, 16'sd512, 0, 16'sd1, -16'sd1, 16'sd1,
                                      0, 0, 0));
        send_transform(pack_transform(0, 16'sd512, 0, 16'sd512, -16'sd1, 16'sd1, -16'sd1,
                                      0, 0, 0));
        send_transform(pack_transform(16'h8000, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                      0, 0, 0));
        send_transform(pack_transform(16'sd16384, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000,
                                      0, 0, 0));
        send_transform(pack_transform(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                      16'h5555, 16'hAAAA, 16'h5555,
                                      32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        send_transform(pack_transform(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                      16'hAAAA, 16'h5555, 16'hAAAA,
                                      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        send_transform(pack_transform(16'sd11585, 0, 16'sd11585, 0, 16'sd384, 16'sd128,
                                      -16'sd640, 32'h0010_8000, 32'hFFF0_8000, 0));
    endtask

    task automatic test_unit_quaternions(int unsigned n);
        repeat (n) begin
            send_transform(pack_transform(near_unit_component(), near_unit_component(),
                                          near_unit_component(), near_unit_component(),
                                          moderate_scale(), moderate_scale(),
                                          moderate_scale(),
                                          $urandom, $urandom, $urandom));
        end
    endtask

    task automatic test_full_range(int unsigned n);
        repeat (n) begin
            send_transform(pack_transform(16'($urandom), 16'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom), 16'($urandom),
                                          16'($urandom), $urandom, $urandom, $urandom));
        end
    endtask

    task automatic test_back_to_back(int unsigned n);
        idle_on = 1'b0;
        test_unit_quaternions(n / 2);
        test_full_range(n - n / 2);
        idle_on = 1'b1;
    endtask

    task automatic finish_run();
        s_tvalid <= 1'b0;
        while (pending_matrices.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Checked %0d transform matrices, %0d rotation-scale entries saturated.",
                 matrix_count, saturated_count);
        $display("Covered extremes, rounding ties, near-unit and full-range inputs, stalls.");
        if (mismatch_count == 0 && pending_matrices.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    endtask

    initial begin
        test_reset();
        test_directed();
        test_unit_quaternions(400);
        test_full_range(400);
        test_back_to_back(200);
        test_unit_quaternions(50);
        finish_run();
    end

    always @(posedge aclk) begin
        int unsigned wait_draw;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1) begin
                m_tready <= 1'b1;
            end
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else if (m_tvalid && idle_on) begin
            wait_draw = $urandom_range(0, 3);
            if (wait_draw != 0) begin
                m_tready   <= 1'b0;
                ready_hold <= wait_draw;
            end
        end
    end

    always @(posedge aclk) begin
        logic [OUT_DATA_W-1:0] expected;
        logic [OUT_W-1:0]      exp_entry;
        logic [OUT_W-1:0]      act_entry;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_matrices.size() == 0) begin
                $display("%0t: unexpected transaction on result channel, data %h",
                         $realtime, m_tdata);
                mismatch_count++;
            end else begin
                expected = pending_matrices.pop_front();
                matrix_count++;
                for (int k = 0; k < NUM_ENTRIES; k++) begin
                    exp_entry = expected[k*OUT_W +: OUT_W];
                    act_entry = m_tdata[k*OUT_W +: OUT_W];
                    if ((k % NUM_COLS) != NUM_COLS - 1 &&
                        (exp_entry == 32'h7FFF_FFFF || exp_entry == 32'h8000_0000)) begin
                        saturated_count++;
                    end
                    if (act_entry !== exp_entry) begin
                        $display("%0t: mismatch m_r%0d_c%0d expected %h actual %h",
                                 $realtime, k / NUM_COLS, k % NUM_COLS, exp_entry, act_entry);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $realtime, pending_matrices.size());
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+src
src/qstm_pkg.sv
src/qstm_prod.sv
src/qstm_rot.sv
src/qstm_mul.sv
src/qstm_rnd.sv
src/quaternion_scale_translate_to_matrix_top.sv
dv/tb_quaternion_scale_translate_to_matrix_top.sv
